>>> src/bic_pkg.sv
// bank interval coalescer shared package
// types, constants and command/status structs; no dependencies
package bic_pkg;

    localparam int TableCapacity = 64;
    localparam int AddrW  = 24;
    localparam int LenW   = 17;
    localparam int CountW = 7;
    localparam int StatW  = 2;
    localparam int IdxW   = 6;

    localparam logic [AddrW-1:0] BankMask = 24'hFF0000;
    localparam logic [LenW-1:0]  MaxLen   = 17'h10000;

    localparam logic ActRecord = 1'b0;
    localparam logic ActRead   = 1'b1;

    localparam logic [StatW-1:0] StatOk   = 2'd0;
    localparam logic [StatW-1:0] StatFull = 2'd1;
    localparam logic [StatW-1:0] StatIdx  = 2'd2;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_CHECK,
        CMD_READ,
        CMD_FINISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic read_done;
    } ctrl_stat_t;

endpackage

>>> src/bank_interval_coalescer_unit.sv
// bank interval coalescer top level
// depends on bic_pkg, bic_ctrl, bic_datapath, bic_ram
//
// keeps a sorted table of written ranges (start, length) in a 24-bit space
// split into 64 KiB banks; a record word merges the range with same-bank
// neighbors it touches and inserts the result, a read word returns one entry
// s_axis: one word per item, tuser = action (0 record, 1 read)
// m_axis: one word per item, tuser = status
// record: the scan copies the table entries in order between two ping-pong
// banks, one entry per cycle unless an entry is held and looked at again
// read: passes the load, read and fetch states before its word is offered
// one item in flight at a time; s_axis_tready is high only when idle and
// returns in the cycle after the result word is taken
// a stalled m_axis holds its word and blocks new input
// reset empties the table at once, no clearing pass
// status 1 means table full and insert dropped, 2 read index beyond count
module bank_interval_coalescer_unit #(
    parameter int TableCapacity = bic_pkg::TableCapacity
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_address[23:0], byte_count[40:24], entry_index[46:41], zero fill
    input  logic [47:0]  s_axis_tdata,
    // action
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_start[23:0], entry_length[40:24], entry_count[47:41]
    output logic [47:0]  m_axis_tdata,
    // status
    output logic [1:0]   m_axis_tuser
);
    bic_pkg::ctrl_cmd_t  cmd;
    bic_pkg::ctrl_stat_t stat;
    logic [bic_pkg::AddrW-1:0]  rs;
    logic [bic_pkg::LenW-1:0]   rl;
    logic [bic_pkg::CountW-1:0] rc;

    bic_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .in_action(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .cmd(cmd), .stat(stat));

    bic_datapath #(.Capacity(TableCapacity)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_start(s_axis_tdata[23:0]),
        .in_count(s_axis_tdata[40:24]),
        .in_index(s_axis_tdata[46:41]),
        .res_start(rs), .res_len(rl), .res_count(rc), .res_status(m_axis_tuser));

    assign m_axis_tdata = {rc, rl, rs};
endmodule

>>> src/bic_ram.sv
// generic simple dual port ram (one write, one read port) with registered read
// no dependencies
module bic_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

>>> src/bic_datapath.sv
// bank interval coalescer datapath: table stores, compaction scan, result registers
// depends on bic_pkg and bic_ram
module bic_datapath #(
    parameter int Capacity = bic_pkg::TableCapacity
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bic_pkg::ctrl_cmd_t            cmd,
    output bic_pkg::ctrl_stat_t           stat,
    input  logic [bic_pkg::AddrW-1:0]     in_start,
    input  logic [bic_pkg::LenW-1:0]      in_count,
    input  logic [bic_pkg::IdxW-1:0]      in_index,
    output logic [bic_pkg::AddrW-1:0]     res_start,
    output logic [bic_pkg::LenW-1:0]      res_len,
    output logic [bic_pkg::CountW-1:0]    res_count,
    output logic [bic_pkg::StatW-1:0]     res_status
);
    localparam int AW = $clog2(Capacity);
    localparam int CW = $clog2(Capacity + 1);
    localparam int EW = bic_pkg::AddrW + 2;

    logic              pp_reg, pp_next;
    logic [CW-1:0]     total_reg, total_next;
    logic [CW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     wr_reg, wr_next;
    logic              rvalid_reg, rvalid_next;
    logic [AW-1:0]     ridx_reg, ridx_next;
    logic [1:0]        phase_reg, phase_next;
    logic              inserted_reg, inserted_next;
    logic              pend_reg, pend_next;
    logic [bic_pkg::AddrW-1:0] ps_reg, ps_next;
    logic [EW-1:0]             pe_reg, pe_next;
    logic [bic_pkg::AddrW-1:0] ns_reg, ns_next;
    logic [EW-1:0]             ne_reg, ne_next;
    logic [bic_pkg::IdxW-1:0]  idx_reg, idx_next;
    logic [bic_pkg::AddrW-1:0] rs_reg, rs_next;
    logic [bic_pkg::LenW-1:0]  rl_reg, rl_next;
    logic [bic_pkg::StatW-1:0] st_reg, st_next;
    logic [bic_pkg::CountW-1:0] rc_reg, rc_next;

    logic [1:0]                we;
    logic [AW-1:0]             waddr;
    logic [bic_pkg::AddrW-1:0] wstart;
    logic [bic_pkg::LenW-1:0]  wlen;
    logic [AW-1:0]             raddr;
    logic [bic_pkg::AddrW-1:0] rs_a [2];
    logic [bic_pkg::LenW-1:0]  rl_a [2];
    logic [bic_pkg::AddrW-1:0] cur_s;
    logic [bic_pkg::LenW-1:0]  cur_l;
    logic [EW-1:0]             cur_e;

    // two banks, ping-pong: scan reads pp_reg, writes the other
    for (genvar b = 0; b < 2; b++) begin : g_bank
        bic_ram #(.Width(bic_pkg::AddrW), .Depth(Capacity)) u_s (
            .aclk(aclk), .we(we[b]), .waddr(waddr), .wdata(wstart),
            .raddr(raddr), .rdata(rs_a[b]));
        bic_ram #(.Width(bic_pkg::LenW), .Depth(Capacity)) u_l (
            .aclk(aclk), .we(we[b]), .waddr(waddr), .wdata(wlen),
            .raddr(raddr), .rdata(rl_a[b]));
    end

    assign cur_s = rs_a[pp_reg];
    assign cur_l = rl_a[pp_reg];
    assign cur_e = EW'(cur_s) + EW'(cur_l);
    // address issued in the cycle before the entry it returns
    assign raddr = (cmd.op == bic_pkg::CMD_READ) ? AW'(idx_reg) : ridx_next;

    function automatic logic [bic_pkg::LenW-1:0] sat_len(input logic [EW-1:0] e,
                                                         input logic [bic_pkg::AddrW-1:0] s);
        logic [EW-1:0] d;
        d = e - EW'(s);
        sat_len = (d > EW'(bic_pkg::MaxLen)) ? bic_pkg::MaxLen : d[bic_pkg::LenW-1:0];
    endfunction

    always_comb begin
        logic [bic_pkg::LenW-1:0] n;
        logic [bic_pkg::LenW-1:0] nl;
        logic                     same;
        logic                     hold;
        pp_next = pp_reg; total_next = total_reg; rd_next = rd_reg; wr_next = wr_reg;
        rvalid_next = 1'b0; ridx_next = ridx_reg; phase_next = phase_reg;
        inserted_next = inserted_reg; pend_next = pend_reg;
        ps_next = ps_reg; pe_next = pe_reg; ns_next = ns_reg; ne_next = ne_reg;
        idx_next = idx_reg;
        rs_next = rs_reg; rl_next = rl_reg; st_next = st_reg; rc_next = rc_reg;
        we = 2'b00; waddr = wr_reg[AW-1:0]; wstart = ps_reg;
        wlen = sat_len(pe_reg, ps_reg);
        stat.scan_done = 1'b0; stat.read_done = 1'b0;
        n = (in_count > bic_pkg::MaxLen) ? bic_pkg::MaxLen : in_count;
        same = 1'b0;
        hold = 1'b0;
        nl = '0;
        case (cmd.op)
            bic_pkg::CMD_LOAD: begin
                idx_next = in_index;
                ns_next = in_start; ne_next = EW'(in_start) + EW'(n);
                rd_next = '0; wr_next = '0; ridx_next = '0;
                phase_next = 2'd0; pend_next = 1'b0; inserted_next = 1'b0;
                rvalid_next = (total_reg != '0);
            end
            bic_pkg::CMD_CHECK: begin
                if (rvalid_reg) begin
                    same = (cur_s & bic_pkg::BankMask) == (ns_reg & bic_pkg::BankMask);
                    case (phase_reg)
                        2'd0: begin
                            if (cur_s < ns_reg) begin
                                if (pend_reg) begin
                                    we[~pp_reg] = 1'b1;
                                    wr_next = wr_reg + 1'b1;
                                end
                                pend_next = 1'b1; ps_next = cur_s; pe_next = cur_e;
                            end else begin
                                if (pend_reg && ((ps_reg & bic_pkg::BankMask) ==
                                    (ns_reg & bic_pkg::BankMask)) && pe_reg >= EW'(ns_reg)) begin
                                    ns_next = ps_reg;
                                    if (pe_reg > ne_reg) ne_next = pe_reg;
                                    pend_next = 1'b0;
                                end else if (pend_reg) begin
                                    // write port busy, look at this entry again next cycle
                                    we[~pp_reg] = 1'b1;
                                    wr_next = wr_reg + 1'b1;
                                    pend_next = 1'b0;
                                    hold = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    // phase 0 falls through to absorb check on the same entry
                    if (phase_reg == 2'd1 ||
                        (phase_reg == 2'd0 && !(cur_s < ns_reg) && !hold)) begin
                        if (phase_reg == 2'd1) begin
                            if (pend_reg) begin
                                we[~pp_reg] = 1'b1;
                                wr_next = wr_reg + 1'b1;
                            end
                            pend_next = 1'b1; ps_next = cur_s; pe_next = cur_e;
                        end else begin
                            logic [bic_pkg::AddrW-1:0] s_eff;
                            logic [EW-1:0]             e_eff;
                            s_eff = ns_next; e_eff = ne_next;
                            if (same && e_eff >= EW'(cur_s)) begin
                                if (cur_e > e_eff) ne_next = cur_e;
                            end else begin
                                // insert new range, then hold current entry
                                wstart = s_eff; wlen = sat_len(e_eff, s_eff);
                                we[~pp_reg] = 1'b1;
                                waddr = wr_next[AW-1:0];
                                wr_next = wr_next + 1'b1;
                                inserted_next = 1'b1;
                                pend_next = 1'b1; ps_next = cur_s; pe_next = cur_e;
                                phase_next = 2'd1;
                            end
                        end
                    end
                    if (hold) begin
                        ridx_next = rd_reg[AW-1:0];
                        rvalid_next = 1'b1;
                    end else begin
                        rd_next = rd_reg + 1'b1;
                        if (rd_next < total_reg) begin
                            ridx_next = rd_next[AW-1:0];
                            rvalid_next = 1'b1;
                        end
                    end
                end else begin
                    // end of table: flush pending, insert if not yet
                    if (pend_reg) begin
                        if (!inserted_reg && phase_reg == 2'd0 &&
                            ((ps_reg & bic_pkg::BankMask) == (ns_reg & bic_pkg::BankMask)) &&
                            pe_reg >= EW'(ns_reg)) begin
                            ns_next = ps_reg;
                            if (pe_reg > ne_reg) ne_next = pe_reg;
                        end else begin
                            we[~pp_reg] = 1'b1;
                            wr_next = wr_reg + 1'b1;
                        end
                        pend_next = 1'b0;
                    end else begin
                        nl = sat_len(ne_reg, ns_reg);
                        stat.scan_done = 1'b1;
                        rs_next = ns_reg; rl_next = nl;
                        if (inserted_reg) begin
                            if (wr_reg <= CW'(Capacity)) begin
                                pp_next = ~pp_reg; total_next = wr_reg;
                                st_next = bic_pkg::StatOk;
                            end else begin
                                st_next = bic_pkg::StatFull;
                            end
                        end else if (wr_reg < CW'(Capacity)) begin
                            we[~pp_reg] = 1'b1; wstart = ns_reg; wlen = nl;
                            pp_next = ~pp_reg; total_next = wr_reg + 1'b1;
                            st_next = bic_pkg::StatOk;
                        end else begin
                            st_next = bic_pkg::StatFull;
                        end
                        rc_next = bic_pkg::CountW'(total_next);
                    end
                end
            end
            bic_pkg::CMD_READ: begin
                rvalid_next = 1'b1;
            end
            bic_pkg::CMD_FINISH: begin
                stat.read_done = 1'b1;
                if (CW'(idx_reg) < total_reg && (CW > bic_pkg::IdxW ||
                    idx_reg < bic_pkg::IdxW'(Capacity))) begin
                    rs_next = cur_s; rl_next = cur_l; st_next = bic_pkg::StatOk;
                end else begin
                    rs_next = '0; rl_next = '0; st_next = bic_pkg::StatIdx;
                end
                rc_next = bic_pkg::CountW'(total_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_reg <= 1'b0; total_reg <= '0; rvalid_reg <= 1'b0;
        end else begin
            pp_reg <= pp_next; total_reg <= total_next; rvalid_reg <= rvalid_next;
        end
        rd_reg <= rd_next; wr_reg <= wr_next; ridx_reg <= ridx_next;
        phase_reg <= phase_next; inserted_reg <= inserted_next; pend_reg <= pend_next;
        ps_reg <= ps_next; pe_reg <= pe_next; ns_reg <= ns_next; ne_reg <= ne_next;
        idx_reg <= idx_next;
        rs_reg <= rs_next; rl_reg <= rl_next; st_reg <= st_next; rc_reg <= rc_next;
    end

    assign res_start = rs_reg;
    assign res_len = rl_reg;
    assign res_count = rc_reg;
    assign res_status = st_reg;
endmodule

>>> src/bic_ctrl.sv
// bank interval coalescer controller: handshake and sequencing of the datapath
// depends on bic_pkg
module bic_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic                 in_action,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output bic_pkg::ctrl_cmd_t   cmd,
    input  bic_pkg::ctrl_stat_t  stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_FETCH, S_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd.op = bic_pkg::CMD_IDLE;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.op = bic_pkg::CMD_LOAD;
                    state_next = (in_action == bic_pkg::ActRead) ? S_READ : S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.op = bic_pkg::CMD_CHECK;
                if (stat.scan_done) state_next = S_OUT;
            end
            S_READ: begin
                cmd.op = bic_pkg::CMD_READ;
                state_next = S_FETCH;
            end
            S_FETCH: begin
                cmd.op = bic_pkg::CMD_FINISH;
                if (stat.read_done) state_next = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
endmodule

>>> src/bic_checker.sv
// port-level checks for the bank interval coalescer
// depends on bic_pkg and bank_interval_coalescer_unit (bound below)
module bic_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while result pending");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= bic_pkg::StatIdx)
        else $error("bad status");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[47:41] <= 7'd64)
        else $error("count beyond capacity");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == bic_pkg::StatIdx |-> m_axis_tdata[40:0] == '0)
        else $error("out of range read not zero");
endmodule

bind bank_interval_coalescer_unit bic_checker u_bic_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser));

>>> test/tb_bank_interval_coalescer_unit.sv
// testbench for bank_interval_coalescer_unit: drives record and read words,
// predicts each result from a local copy of the range table and compares
// depends on bic_pkg and the bank_interval_coalescer_unit rtl
`timescale 1ns / 100ps

module tb_bank_interval_coalescer_unit;

    typedef struct packed {
        logic [bic_pkg::AddrW-1:0]  start;
        logic [bic_pkg::LenW-1:0]   len;
        logic [bic_pkg::CountW-1:0] count;
        logic [bic_pkg::StatW-1:0]  stat;
    } entry_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    bank_interval_coalescer_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // local copy of the range table
    logic [bic_pkg::AddrW-1:0] tbl_start [bic_pkg::TableCapacity];
    logic [bic_pkg::LenW-1:0]  tbl_len [bic_pkg::TableCapacity];
    int                        tbl_total = 0;

    entry_word_t pending_words[$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;
    logic [7:0]  stall_pat = 8'b1011_0110;
    int          stall_mode = 0;

    function automatic void remove_range(int pos);
        for (int i = pos; i + 1 < tbl_total; i++) begin
            tbl_start[i] = tbl_start[i+1];
            tbl_len[i] = tbl_len[i+1];
        end
        tbl_total--;
    endfunction

    function automatic entry_word_t coalesce_range(logic act, logic [23:0] sa,
                                                   logic [16:0] cnt, logic [5:0] idx);
        entry_word_t w;
        int unsigned s, n, e, pend, pos, bank;
        w = '0;
        if (act == bic_pkg::ActRecord) begin
            s = sa;
            n = (cnt > bic_pkg::MaxLen) ? bic_pkg::MaxLen : cnt;
            e = s + n;
            bank = s & bic_pkg::BankMask;
            pos = 0;
            while (pos < tbl_total && tbl_start[pos] < s) pos++;
            if (pos > 0 && (tbl_start[pos-1] & bic_pkg::BankMask) == bank &&
                tbl_start[pos-1] + tbl_len[pos-1] >= s) begin
                pend = tbl_start[pos-1] + tbl_len[pos-1];
                if (pend > e) e = pend;
                s = tbl_start[pos-1];
                remove_range(pos - 1);
                pos--;
            end
            while (pos < tbl_total && (tbl_start[pos] & bic_pkg::BankMask) == bank &&
                   e >= tbl_start[pos]) begin
                pend = tbl_start[pos] + tbl_len[pos];
                if (pend > e) e = pend;
                remove_range(pos);
            end
            n = e - s;
            if (n > bic_pkg::MaxLen) n = bic_pkg::MaxLen;
            if (tbl_total < bic_pkg::TableCapacity) begin
                for (int i = tbl_total; i > pos; i--) begin
                    tbl_start[i] = tbl_start[i-1];
                    tbl_len[i] = tbl_len[i-1];
                end
                tbl_start[pos] = s[23:0];
                tbl_len[pos] = n[16:0];
                tbl_total++;
            end else begin
                w.stat = bic_pkg::StatFull;
            end
            w.start = s[23:0];
            w.len = n[16:0];
        end else if (idx < tbl_total) begin
            w.start = tbl_start[idx];
            w.len = tbl_len[idx];
        end else begin
            w.stat = bic_pkg::StatIdx;
        end
        w.count = tbl_total[6:0];
        return w;
    endfunction

    task automatic send_word(logic act, logic [23:0] sa, logic [16:0] cnt, logic [5:0] idx);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {1'b0, idx, cnt, sa};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_words = {pending_words, coalesce_range(act, sa, cnt, idx)};
    endtask

    // receiver stall pattern and checker
    always @(posedge aclk) begin
        entry_word_t got, exp;
        cycles <= cycles + 1;
        stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5]};
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= stall_pat[0];
            default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[23:0], m_axis_tdata[40:24], m_axis_tdata[47:41],
                   m_axis_tuser};
            if (pending_words.size() == 0) begin
                $display("%0t unexpected word: actual %h", $time, got);
                errors++;
            end else begin
                exp = pending_words.pop_front();
                if (got.start !== exp.start)
                    $display("%0t start: expected %h actual %h", $time, exp.start, got.start);
                if (got.len !== exp.len)
                    $display("%0t length: expected %h actual %h", $time, exp.len, got.len);
                if (got.count !== exp.count)
                    $display("%0t count: expected %0d actual %0d", $time, exp.count, got.count);
                if (got.stat !== exp.stat)
                    $display("%0t status: expected %0d actual %0d", $time, exp.stat, got.stat);
                if (got !== exp) errors++;
            end
        end
        if (cycles > 2000000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic read_all();
        for (int i = 0; i <= tbl_total && i < 64; i++)
            send_word(bic_pkg::ActRead, 24'($urandom), 17'($urandom), 6'(i));
    endtask

    task automatic test_directed();
        send_word(bic_pkg::ActRead, 24'h0, 17'h0, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h000000, 17'h0, 6'd63);
        send_word(bic_pkg::ActRecord, 24'hFFFFFF, 17'h1FFFF, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h010000, 17'h10000, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h01FFF0, 17'h10000, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h020000, 17'h00010, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h000100, 17'h00100, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h000300, 17'h00100, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h000200, 17'h00100, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h000050, 17'h00000, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h000000, 17'h00050, 6'd0);
        send_word(bic_pkg::ActRecord, 24'hAAAAAA, 17'h15555, 6'd0);
        send_word(bic_pkg::ActRecord, 24'h555555, 17'h0AAAA, 6'd0);
        read_all();
    endtask

    // fill the table with isolated ranges until inserts are dropped
    task automatic test_table_full();
        for (int i = 0; i < 70; i++)
            send_word(bic_pkg::ActRecord, {i[7:0] ^ 8'h5A, 16'h1000},
                      17'($urandom_range(0, 255)), 6'd0);
        send_word(bic_pkg::ActRecord, 24'hFF8000, 17'h1, 6'd0);
        read_all();
    endtask

    task automatic test_random(int items, int banks);
        logic [23:0] sa;
        for (int i = 0; i < items; i++) begin
            sa = {8'($urandom_range(0, banks - 1)) ^ 8'($urandom_range(0, 1) ? 8'hFF : 0),
                  16'($urandom)};
            if (($urandom_range(0, 3)) == 0) begin
                send_word(bic_pkg::ActRead, 24'($urandom), 17'($urandom), 6'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    0: send_word(bic_pkg::ActRecord, sa, 17'($urandom), 6'($urandom));
                    1: send_word(bic_pkg::ActRecord, sa, 17'($urandom_range(0, 64)),
                                 6'($urandom));
                    2: send_word(bic_pkg::ActRecord, sa, 17'($urandom_range(0, 4096)),
                                 6'($urandom));
                    default: send_word(bic_pkg::ActRecord, sa, 17'h10000, 6'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        stall_mode = 1;
        test_table_full();
        stall_mode = 2;
        test_random(400, 4);
        stall_mode = 0;
        test_random(500, 2);
        stall_mode = 1;
        test_random(450, 256);
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
